// ===== src/kfc_pkg.sv =====
// Package with the result word type, the push bundle and the framing constants.
`timescale 1ns / 1ps

package kfc_pkg;

    localparam logic MODE_KWP = 1'b0;
    localparam logic MODE_ISO = 1'b1;

    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [8:0] KWP_LEN_BYTE_POS = 9'd4;
    localparam logic [8:0] KWP_EXT_LEN_ADD  = 9'd5;
    localparam logic [8:0] KWP_FMT_LEN_ADD  = 9'd4;
    localparam logic [8:0] KWP_SHORT_ADD    = 9'd2;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       is_checksum;
        logic       frame_end;
        logic       bad_header;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== src/kline_frame_length_checksum_top.sv =====
// Top level of the K-line transmit framer with length detection and checksum.
//
//   Channel   Direction  Handshake                     Payload
//   tx        in         i_tx_valid / o_tx_ready       i_tx_byte
//   line      out        o_line_valid / i_line_ready   o_line_byte, o_is_checksum,
//                                                      o_frame_end, o_bad_header
//   cfg       in         i_cfg_we                      i_cfg_wdata (frame mode)
//
// One input word is taken per cycle while o_tx_ready is high; its result words enter a
// four-word output queue at the same edge and can leave in the next cycle, one word per
// cycle while i_line_ready is high. The last data word of a frame yields two words, so
// o_tx_ready holds only while the queue has room for two; the queue drain sets the rate.
// Reset is synchronous and active low and clears the frame state, the mode and the queue.
// A stall on the line side backs up into the queue and then into o_tx_ready.
`timescale 1ns / 1ps

module kline_frame_length_checksum_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_tx_valid,
    output logic       o_tx_ready,
    input  logic [7:0] i_tx_byte,
    output logic       o_line_valid,
    input  logic       i_line_ready,
    output logic [7:0] o_line_byte,
    output logic       o_is_checksum,
    output logic       o_frame_end,
    output logic       o_bad_header
);

    kfc_pkg::t_push   push;
    kfc_pkg::t_result result;
    logic             accept;

    assign accept = i_tx_valid && o_tx_ready;

    kfc_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_tx_byte   (i_tx_byte),
        .o_push      (push)
    );

    kfc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (o_tx_ready),
        .o_valid  (o_line_valid),
        .i_ready  (i_line_ready),
        .o_result (result)
    );

    assign o_line_byte   = result.line_byte;
    assign o_is_checksum = result.is_checksum;
    assign o_frame_end   = result.frame_end;
    assign o_bad_header  = result.bad_header;

endmodule

// ===== src/kfc_framer.sv =====
// Frame state, length detection and checksum; emits up to two result words per input word.
`timescale 1ns / 1ps

module kfc_framer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_accept,
    input  logic [7:0]    i_tx_byte,
    output kfc_pkg::t_push o_push
);

    logic       r_mode;
    logic       r_in_frame;
    logic [8:0] r_pos;
    logic [8:0] r_len;
    logic       r_len_known;
    logic [7:0] r_sum;

    logic       n_in_frame;
    logic [8:0] n_pos;
    logic [8:0] n_len;
    logic       n_len_known;
    logic [7:0] n_sum;

    kfc_pkg::t_result data_res;
    kfc_pkg::t_result err_res;
    kfc_pkg::t_result cks_res;
    logic             fin;

    always_comb begin
        data_res = '{line_byte: i_tx_byte, is_checksum: 1'b0, frame_end: 1'b0,
                     bad_header: 1'b0};
        err_res  = '{line_byte: 8'd0, is_checksum: 1'b0, frame_end: 1'b1,
                     bad_header: 1'b1};

        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_len       = r_len;
        n_len_known = r_len_known;
        n_sum       = r_sum;
        o_push      = '0;

        if (i_accept) begin
            if (!r_in_frame) begin
                if (r_mode == kfc_pkg::MODE_ISO) begin
                    if (i_tx_byte == 8'd0) begin
                        o_push.res0  = err_res;
                        o_push.count = 2'd1;
                    end else begin
                        n_in_frame  = 1'b1;
                        n_len       = {1'b0, i_tx_byte};
                        n_len_known = 1'b1;
                        n_pos       = 9'd0;
                        n_sum       = 8'd0;
                    end
                end else if (i_tx_byte[7] || !i_tx_byte[6]) begin
                    if (i_tx_byte[7]) begin
                        if (i_tx_byte[3:0] == 4'd0) begin
                            n_len_known = 1'b0;
                            n_len       = 9'd0;
                        end else begin
                            n_len_known = 1'b1;
                            n_len       = {3'd0, i_tx_byte[5:0]} + kfc_pkg::KWP_FMT_LEN_ADD;
                        end
                    end else begin
                        n_len_known = 1'b1;
                        n_len       = {1'b0, i_tx_byte} + kfc_pkg::KWP_SHORT_ADD;
                    end
                    n_in_frame   = 1'b1;
                    n_pos        = 9'd1;
                    n_sum        = i_tx_byte;
                    o_push.res0  = data_res;
                    o_push.count = 2'd1;
                end else begin
                    o_push.res0  = err_res;
                    o_push.count = 2'd1;
                end
            end else begin
                o_push.res0  = data_res;
                o_push.count = 2'd1;
                n_sum        = r_sum + i_tx_byte;
                n_pos        = r_pos + 9'd1;
                if (!r_len_known && n_pos == kfc_pkg::KWP_LEN_BYTE_POS) begin
                    n_len       = {1'b0, i_tx_byte} + kfc_pkg::KWP_EXT_LEN_ADD;
                    n_len_known = 1'b1;
                end
            end
        end

        cks_res = '{line_byte: n_sum, is_checksum: 1'b1, frame_end: 1'b1, bad_header: 1'b0};
        fin     = i_accept && n_in_frame && n_len_known
                  && (({1'b0, n_pos} + 10'd1) == {1'b0, n_len});

        if (fin) begin
            if (o_push.count == 2'd0) begin
                o_push.res0 = cks_res;
            end else begin
                o_push.res1 = cks_res;
            end
            o_push.count = o_push.count + 2'd1;
            n_in_frame   = 1'b0;
            n_pos        = 9'd0;
            n_len        = 9'd0;
            n_len_known  = 1'b0;
            n_sum        = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kfc_pkg::MODE_KWP;
            r_in_frame  <= 1'b0;
            r_pos       <= 9'd0;
            r_len       <= 9'd0;
            r_len_known <= 1'b0;
            r_sum       <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_in_frame  <= n_in_frame;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_len_known <= n_len_known;
            r_sum       <= n_sum;
        end
    end

`ifndef SYNTHESIS
    a_two_ends_in_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.res1.is_checksum && o_push.res1.frame_end
                                    && !o_push.res0.frame_end))
        else $error("second word of a push is not the closing checksum");

    a_len_pending_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_frame && !r_len_known) |-> (r_pos < kfc_pkg::KWP_LEN_BYTE_POS))
        else $error("length byte position passed without a known length");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_sum == 8'd0 && r_pos == 9'd0 && !r_len_known))
        else $error("framer idle with stale frame state");
`endif

endmodule

// ===== src/kfc_outq.sv =====
// Small output queue that takes up to two result words per cycle and hands out one.
`timescale 1ns / 1ps

module kfc_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kfc_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output kfc_pkg::t_result o_result
);

    kfc_pkg::t_result r_mem [kfc_pkg::OUTQ_DEPTH];

    logic [kfc_pkg::OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [kfc_pkg::OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [kfc_pkg::OUTQ_CNT_W-1:0] r_count;
    logic [kfc_pkg::OUTQ_PTR_W-1:0] wr_ptr_1;
    logic                           pop;

    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = r_wr_ptr + kfc_pkg::OUTQ_PTR_W'(1);
    assign o_room   = (r_count <= kfc_pkg::OUTQ_CNT_W'(kfc_pkg::OUTQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + kfc_pkg::OUTQ_PTR_W'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + kfc_pkg::OUTQ_PTR_W'(1);
            end
            r_count <= r_count + kfc_pkg::OUTQ_CNT_W'(i_push.count)
                       - kfc_pkg::OUTQ_CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kfc_pkg::OUTQ_CNT_W'(kfc_pkg::OUTQ_DEPTH))
        else $error("output queue holds more words than its depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("words pushed without room for two");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.count == 2'd0)
        |=> (r_count == $past(r_count) - kfc_pkg::OUTQ_CNT_W'(1)))
        else $error("queue fill did not drop after a lone pop");
`endif

endmodule
